>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL; they expand to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SETL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define SETL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`define SETL_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed: forbidden condition");
`else
`define SETL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SETL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define SETL_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> rtl/setl_pkg.sv
// Types, constants and request codes of the scanline edge table fill unit.
`default_nettype none
package setl_pkg;

	localparam int ROWS   = 512;
	localparam int COLS   = 512;
	localparam int ROW_W  = 9;
	localparam int X_W    = 9;
	localparam int LEFT_W = 10;
	localparam int FRAC_W = 16;
	localparam int QUO_W  = X_W + FRAC_W;
	localparam int ACC_W  = QUO_W + 1;
	localparam int CNT_W  = 5;
	localparam int WORD_W = LEFT_W + X_W;

	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_EDGE  = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	localparam logic [LEFT_W-1:0] LEFT_CLEAR = LEFT_W'(COLS);

	typedef struct packed {
		logic [1:0]       req_type;
		logic [X_W-1:0]   start_x;
		logic [ROW_W-1:0] start_y;
		logic [X_W-1:0]   end_x;
		logic [ROW_W-1:0] end_y;
		logic [ROW_W-1:0] query_row;
	} req_t;

	typedef struct packed {
		logic [LEFT_W-1:0] span_left;
		logic [X_W-1:0]    span_right;
		logic              span_nonempty;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_CLEAR,
		ST_DIV,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic cap;
		logic clr_wr;
		logic div_start;
		logic walk_rd;
		logic q_rd;
		logic res_ld;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       clr_last;
		logic       horiz;
		logic       div_done;
		logic       walk_last;
	} sts_t;

endpackage
`default_nettype wire

>>> rtl/setl_div.sv
// Restoring divider, one quotient bit per cycle, for the edge slope.
`default_nettype none
`include "assert_macros.svh"
module setl_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [setl_pkg::QUO_W-1:0] dividend,
	input  wire logic [setl_pkg::X_W-1:0]   divisor,
	output logic      [setl_pkg::QUO_W-1:0] quot,
	output logic                            done
);
	import setl_pkg::*;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [X_W-1:0]    rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [X_W-1:0]    dvs_q;
	logic [X_W:0]      trial;
	logic              fits;
	logic              done_q;

	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift the dividend out at the top and the quotient in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? X_W'(trial - {1'b0, dvs_q}) : trial[X_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign quot = quo_q;
	assign done = done_q;

	`SETL_ASSERT_NEXT(a_start_busy, clk, arst_n, start, busy_q)
	`SETL_ASSERT_NEVER(a_done_while_busy, clk, arst_n, done_q && busy_q)
endmodule
`default_nettype wire

>>> rtl/setl_dp.sv
// Datapath: edge table memory, row counter, x accumulator and result register.
`default_nettype none
`include "assert_macros.svh"
module setl_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire setl_pkg::req_t req,
	input  wire setl_pkg::cmd_t cmd,
	output setl_pkg::sts_t     sts,
	output setl_pkg::rsp_t     rsp,
	output logic               done
);
	import setl_pkg::*;

	logic [WORD_W-1:0] mem [ROWS];
	logic [WORD_W-1:0] rdata_q;
	logic [ROW_W-1:0]  raddr;
	logic [ROW_W-1:0]  waddr;
	logic [WORD_W-1:0] wdata;
	logic              we;

	logic [ROW_W-1:0]  row_q;
	logic [1:0]        req_q;
	logic [X_W-1:0]    xl_q, xh_q;
	logic [ROW_W-1:0]  yl_q, yh_q, qr_q;
	logic              neg_q;
	logic signed [ACC_W-1:0] acc_q, slope_q;

	logic              swap;
	logic [X_W-1:0]    dx_abs;
	logic [ROW_W-1:0]  dy;
	logic [QUO_W-1:0]  quot;
	logic              div_done;
	logic [ACC_W-1:0]  mag;
	logic [X_W-1:0]    fx;

	logic              wv_s1;
	logic [ROW_W-1:0]  wrow_s1;
	logic [X_W-1:0]    wfx_s1;

	logic [LEFT_W-1:0] rd_left, new_left;
	logic [X_W-1:0]    rd_right, new_right;

	rsp_t rsp_q;
	logic done_q;

	assign swap   = req.end_y < req.start_y;
	assign dx_abs = neg_q ? X_W'(xl_q - xh_q) : X_W'(xh_q - xl_q);
	assign dy     = yh_q - yl_q;

	setl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({dx_abs, {FRAC_W{1'b0}}}),
		.divisor  (dy),
		.quot     (quot),
		.done     (div_done)
	);

	assign mag = {1'b0, quot};
	assign fx  = acc_q[ACC_W-1] ? '0 : acc_q[QUO_W-1:FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			wv_s1  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			wv_s1  <= cmd.walk_rd;
			done_q <= cmd.res_ld;
			if (cmd.cap) begin
				row_q <= (req.req_type == REQ_CLEAR) ? '0
					: (swap ? req.end_y : req.start_y);
			end else if (cmd.clr_wr || cmd.walk_rd) begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			req_q <= req.req_type;
			qr_q  <= req.query_row;
			xl_q  <= swap ? req.end_x : req.start_x;
			yl_q  <= swap ? req.end_y : req.start_y;
			xh_q  <= swap ? req.start_x : req.end_x;
			yh_q  <= swap ? req.start_y : req.end_y;
			neg_q <= swap ? (req.start_x < req.end_x) : (req.end_x < req.start_x);
			acc_q <= {1'b0, swap ? req.end_x : req.start_x, {FRAC_W{1'b0}}};
		end else if (cmd.walk_rd) begin
			acc_q <= acc_q + slope_q;
		end
		if (div_done)
			slope_q <= neg_q ? -$signed(mag) : $signed(mag);
		wrow_s1 <= row_q;
		wfx_s1  <= fx;
	end

	// read-modify-write: row read now, merged and written back next cycle
	assign raddr    = cmd.q_rd ? qr_q : row_q;
	assign rd_left  = rdata_q[WORD_W-1:X_W];
	assign rd_right = rdata_q[X_W-1:0];
	assign new_left  = ({1'b0, wfx_s1} < rd_left) ? {1'b0, wfx_s1} : rd_left;
	assign new_right = (wfx_s1 > rd_right) ? wfx_s1 : rd_right;

	assign we    = cmd.clr_wr || wv_s1;
	assign waddr = wv_s1 ? wrow_s1 : row_q;
	assign wdata = wv_s1 ? {new_left, new_right} : {LEFT_CLEAR, {X_W{1'b0}}};

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			if (req_q == REQ_QUERY) begin
				rsp_q.span_left     <= rd_left;
				rsp_q.span_right    <= rd_right;
				rsp_q.span_nonempty <= rd_left < {1'b0, rd_right};
			end else begin
				rsp_q <= '0;
			end
		end
	end

	assign sts.req_type  = req_q;
	assign sts.clr_last  = row_q == ROW_W'(ROWS - 1);
	assign sts.horiz     = yl_q == yh_q;
	assign sts.div_done  = div_done;
	assign sts.walk_last = row_q == yh_q;

	assign rsp  = rsp_q;
	assign done = done_q;

	`SETL_ASSERT_NEVER(a_wr_port_clash, clk, arst_n, wv_s1 && cmd.clr_wr)
	`SETL_ASSERT_NEVER(a_rd_during_walk_wr, clk, arst_n, wv_s1 && cmd.q_rd)
endmodule
`default_nettype wire

>>> rtl/setl_ctrl.sv
// Controller state machine sequencing clear, edge walk and query.
`default_nettype none
`include "assert_macros.svh"
module setl_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire setl_pkg::sts_t sts,
	output setl_pkg::cmd_t      cmd,
	output logic                busy
);
	import setl_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_INIT;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (sts.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start)
					state_d = ST_DECODE;
			end
			ST_DECODE: begin
				unique case (sts.req_type)
					REQ_CLEAR: state_d = ST_CLEAR;
					REQ_EDGE:  state_d = sts.horiz ? ST_WALK : ST_DIV;
					default:   state_d = ST_DONE;
				endcase
			end
			ST_CLEAR: begin
				if (sts.clr_last)
					state_d = ST_DONE;
			end
			ST_DIV: begin
				if (sts.div_done)
					state_d = ST_WALK;
			end
			ST_WALK: begin
				if (sts.walk_last)
					state_d = ST_DONE;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_INIT:   cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				busy    = 1'b0;
				cmd.cap = start;
			end
			ST_DECODE: begin
				cmd.div_start = (sts.req_type == REQ_EDGE) && !sts.horiz;
				cmd.q_rd      = sts.req_type == REQ_QUERY;
			end
			ST_CLEAR:  cmd.clr_wr  = 1'b1;
			ST_DIV:    cmd         = '0;
			ST_WALK:   cmd.walk_rd = 1'b1;
			ST_DONE:   cmd.res_ld  = 1'b1;
			default:   cmd         = '0;
		endcase
	end

	`SETL_ASSERT_NEXT(a_result_then_idle, clk, arst_n, cmd.res_ld, state_q == ST_IDLE)
	`SETL_ASSERT_NEXT(a_walk_end, clk, arst_n, cmd.walk_rd && sts.walk_last,
		state_q == ST_DONE)
	`SETL_ASSERT_NEXT(a_div_to_walk, clk, arst_n, (state_q == ST_DIV) && sts.div_done,
		state_q == ST_WALK)
endmodule
`default_nettype wire

>>> rtl/scanline_edge_table_fill_unit.sv
// Top level of the scanline edge table fill unit.
//
// Keeps per-row left and right edge entries for scanline polygon fill.
// Input: a request is transferred at a rising edge where start is high and busy
// is low; req carries the request type, the edge endpoints and the query row.
// Output: every request gives exactly one result on rsp, marked by done for
// one cycle; the receiver cannot stall it, so it must take the result then.
// Only a query returns data; clear, edge and unused codes return zeros.
// Sequence, from the transfer to done (busy falls in the done cycle):
//   clear: one row written per cycle.
//   edge:  the serial slope divider runs first, then one row is
//          read-modify-written per cycle; a horizontal edge skips the divider.
//   query: one table read; unused codes: no table access.
// Worst case is a full-height edge; the memory port and the one-bit-per-cycle
// divider set how long a request takes.
// After reset the unit sweeps both tables to their cleared values, with busy
// high, before it takes its first request.
`default_nettype none
module scanline_edge_table_fill_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire setl_pkg::req_t req,
	output logic                done,
	output setl_pkg::rsp_t      rsp
);
	import setl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	setl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	setl_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp),
		.done   (done)
	);
endmodule
`default_nettype wire

>>> sim/scanline_edge_table_fill_unit_test.sv
// Self-checking testbench of the scanline edge table fill unit.
`default_nettype none
module scanline_edge_table_fill_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import setl_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int RANDOM_ITEMS = 1110;
	localparam int TAIL_CYCLES = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	// Own copy of the per-row edge tables
	logic [LEFT_W-1:0] row_left [ROWS];
	logic [X_W-1:0] row_right [ROWS];
	rsp_t span_due_q[$];

	bit quiet = 1'b0;
	int fail_count = 0;
	int cycle_count = 0;
	int n_sent = 0;
	int n_clears = 0;
	int n_edges = 0;
	int n_queries = 0;
	int n_unused = 0;
	int n_filled = 0;

	scanline_edge_table_fill_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run stopped: no progress after %0d cycles", cycle_count);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Walk one edge from its lower to its upper row in Q16 steps
	function automatic void trace_edge(input req_t r);
		logic [X_W-1:0] xl, xh;
		logic [ROW_W-1:0] yl, yh;
		int dx, dy, slope, acc, fx;
		if (r.end_y < r.start_y) begin
			xl = r.end_x; yl = r.end_y; xh = r.start_x; yh = r.start_y;
		end else begin
			xl = r.start_x; yl = r.start_y; xh = r.end_x; yh = r.end_y;
		end
		dx = int'(xh) - int'(xl);
		dy = int'(yh) - int'(yl);
		slope = (dy > 0) ? (dx * 65536) / dy : 0;
		acc = int'(xl) * 65536;
		for (int row = int'(yl); row <= int'(yh); row++) begin
			if (acc < 0)
				acc = 0;
			fx = acc >>> FRAC_W;
			if (fx >= COLS)
				fx = COLS - 1;
			if (row < ROWS) begin
				if (fx < int'(row_left[row]))
					row_left[row] = LEFT_W'(fx);
				if (fx > int'(row_right[row]))
					row_right[row] = X_W'(fx);
			end
			acc += slope;
		end
	endfunction

	function automatic rsp_t apply_request(input req_t r);
		rsp_t res;
		res = '0;
		case (r.req_type)
		REQ_CLEAR: begin
			for (int i = 0; i < ROWS; i++) begin
				row_left[i] = LEFT_CLEAR;
				row_right[i] = '0;
			end
		end
		REQ_EDGE: begin
			trace_edge(r);
		end
		REQ_QUERY: begin
			res.span_left = LEFT_CLEAR;
			if (r.query_row < ROWS) begin
				res.span_left = row_left[r.query_row];
				res.span_right = row_right[r.query_row];
			end
			res.span_nonempty = (res.span_left < {1'b0, res.span_right});
		end
		default: begin
			res = '0;
		end
		endcase
		return res;
	endfunction

	// Unused fields carry random values
	function automatic req_t noise_req(input logic [1:0] kind);
		req_t r;
		r.req_type = kind;
		r.start_x = X_W'($urandom);
		r.start_y = ROW_W'($urandom);
		r.end_x = X_W'($urandom);
		r.end_y = ROW_W'($urandom);
		r.query_row = ROW_W'($urandom);
		return r;
	endfunction

	function automatic req_t edge_req(input int x0, input int y0, input int x1, input int y1);
		req_t r;
		r = noise_req(REQ_EDGE);
		r.start_x = X_W'(x0);
		r.start_y = ROW_W'(y0);
		r.end_x = X_W'(x1);
		r.end_y = ROW_W'(y1);
		return r;
	endfunction

	function automatic req_t query_req(input int row);
		req_t r;
		r = noise_req(REQ_QUERY);
		r.query_row = ROW_W'(row);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// Drive one request and hold it until the transfer
	task automatic send_req(input req_t r);
		int gap;
		rsp_t due;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
		due = apply_request(r);
		span_due_q.push_back(due);
		n_sent++;
		case (r.req_type)
		REQ_CLEAR: n_clears++;
		REQ_EDGE:  n_edges++;
		REQ_QUERY: begin
			n_queries++;
			if (due.span_nonempty)
				n_filled++;
		end
		default:   n_unused++;
		endcase
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (span_due_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (span_due_q.size() == 0) begin
				report_mismatch("unexpected result", int'(rsp), -1);
			end else begin
				want = span_due_q.pop_front();
				if (rsp.span_left !== want.span_left)
					report_mismatch("span_left", int'(rsp.span_left), int'(want.span_left));
				if (rsp.span_right !== want.span_right)
					report_mismatch("span_right", int'(rsp.span_right), int'(want.span_right));
				if (rsp.span_nonempty !== want.span_nonempty)
					report_mismatch("span_nonempty", int'(rsp.span_nonempty),
						int'(want.span_nonempty));
			end
		end
	end

	task automatic test_reset_state();
		send_req(query_req(0));
		send_req(query_req(ROWS - 1));
	endtask

	task automatic test_unused_code();
		req_t r;
		r = '1;
		send_req(r);
		send_req(query_req(ROWS - 1));
	endtask

	task automatic test_edge_cases();
		send_req(edge_req(0, 0, 511, 511));
		send_req(query_req(0));
		send_req(query_req(256));
		send_req(query_req(511));
		// horizontal: only the start point lands
		send_req(edge_req(300, 100, 20, 100));
		send_req(query_req(100));
		// endpoints given top-down
		send_req(edge_req(511, 400, 0, 10));
		send_req(query_req(10));
		send_req(query_req(200));
		send_req(query_req(400));
		send_req(edge_req(5, 50, 5, 60));
		send_req(query_req(55));
		send_req(edge_req(511, 511, 511, 511));
		send_req(query_req(511));
	endtask

	task automatic test_clear();
		send_req(noise_req(REQ_CLEAR));
		send_req(query_req(0));
		send_req(query_req(100));
	endtask

	// Closed polygons in a random band of rows, then queries, mostly in that band
	task automatic test_random_polygons(input int target);
		int nv, band, base_y, nq, groups;
		int vx[8];
		int vy[8];
		groups = 0;
		while (n_sent < target) begin
			quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0)
				send_req(noise_req(REQ_CLEAR));
			nv = $urandom_range(2, 6);
			band = ($urandom_range(0, 5) == 0) ? 511 : $urandom_range(0, 48);
			base_y = $urandom_range(0, 511 - band);
			for (int k = 0; k < nv; k++) begin
				vx[k] = $urandom_range(0, 511);
				vy[k] = base_y + $urandom_range(0, band);
				if (k > 0 && $urandom_range(0, 6) == 0)
					vy[k] = vy[k-1];
			end
			for (int k = 0; k < nv; k++)
				send_req(edge_req(vx[k], vy[k], vx[(k+1) % nv], vy[(k+1) % nv]));
			case ($urandom_range(0, 7))
			0: send_req(noise_req(REQ_EDGE));
			1: send_req(noise_req(REQ_UNUSED));
			default: ;
			endcase
			nq = $urandom_range(2, 8);
			for (int k = 0; k < nq; k++) begin
				if ($urandom_range(0, 4) == 0)
					send_req(query_req($urandom_range(0, 511)));
				else
					send_req(query_req(base_y + $urandom_range(0, band)));
			end
			groups++;
			if (groups % 12 == 0)
				wait_drained();
		end
		quiet = 1'b0;
	endtask

	initial begin
		void'(apply_request(noise_req(REQ_CLEAR)));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_unused_code();
		test_edge_cases();
		test_clear();
		test_random_polygons(n_sent + RANDOM_ITEMS);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d requests: %0d clears, %0d edges, %0d unused codes",
			n_sent, n_clears, n_edges, n_unused);
		$display("checked %0d row queries, %0d of them on a filled span",
			n_queries, n_filled);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/setl_pkg.sv
rtl/setl_div.sv
rtl/setl_dp.sv
rtl/setl_ctrl.sv
rtl/scanline_edge_table_fill_unit.sv
sim/scanline_edge_table_fill_unit_test.sv
